@@ sv/quad_diagonal_triangulator_top_assert.svh @@
// ----------------------------------------------------------------------------
// Quad diagonal triangulator assertion macros
// Assertion wrappers shared by the multiplier and controller modules; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef QUAD_DIAGONAL_TRIANGULATOR_TOP_ASSERT_SVH
`define QUAD_DIAGONAL_TRIANGULATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check on every rising edge outside reset
`define QDT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qdt: assertion failed");
// Check on every rising edge, reset included
`define QDT_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("qdt: assertion failed");
`else
`define QDT_ASSERT(label, clk, rst_n, prop)
`define QDT_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ sv/qdt_pkg.sv @@
// ----------------------------------------------------------------------------
// Quad diagonal triangulator package
// Operation codes and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package qdt_pkg;

    // Multiplier digit width: bits of the second operand taken per cycle
    localparam int DIG_BITS = 8;

    // Position of the fourth vertex of a quad
    localparam logic [1:0] SLOT_LAST = 2'd3;
    // Last vector component (z)
    localparam logic [1:0] COMP_LAST = 2'd2;

    // Multiply operation codes
    localparam logic [2:0] KIND_DOT  = 3'd0;  // |a_k|*|b_k| into the dot product
    localparam logic [2:0] KIND_SQA  = 3'd1;  // a_k^2 into |a|^2
    localparam logic [2:0] KIND_SQB  = 3'd2;  // b_k^2 into |b|^2
    localparam logic [2:0] KIND_NORM = 3'd3;  // |a|^2*|b|^2
    localparam logic [2:0] KIND_SQD  = 3'd4;  // dot^2
    localparam logic [2:0] KIND_LHS  = 3'd5;  // dot0^2 * norms of diagonal 1
    localparam logic [2:0] KIND_RHS  = 3'd6;  // dot1^2 * norms of diagonal 0

    typedef struct packed {
        logic       hold_we;  // store the incoming vertex in its slot
        logic [1:0] slot;     // slot of the incoming vertex
        logic       load;     // fourth vertex: form the midpoint vectors
        logic       start;    // launch a multiply
        logic [2:0] kind;     // current multiply operation
        logic       diag;     // diagonal the operation belongs to
        logic [1:0] comp;     // vector component
        logic       emit;     // decide and load the output register
    } t_cmd;

    typedef struct packed {
        logic mul_done;  // product ready this cycle
        logic out_free;  // output register can take a result
    } t_stat;

endpackage

@@ sv/qdt_vertex_if.sv @@
// ----------------------------------------------------------------------------
// Vertex channel
// Valid/ready channel carrying one quad vertex per request.
// ----------------------------------------------------------------------------
interface qdt_vertex_if #(
    parameter int COORD_BITS = 32,
    parameter int INDEX_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [INDEX_BITS-1:0]        vertex_index;

    modport source (output valid, coord_x, coord_y, coord_z, vertex_index, input ready);
    modport sink (input valid, coord_x, coord_y, coord_z, vertex_index, output ready);
endinterface

@@ sv/qdt_tri_if.sv @@
// ----------------------------------------------------------------------------
// Triangle pair channel
// Valid/ready channel carrying the two triangles of one quad per request.
// ----------------------------------------------------------------------------
interface qdt_tri_if #(
    parameter int INDEX_BITS = 24
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] first_tri_a;
    logic [INDEX_BITS-1:0] first_tri_b;
    logic [INDEX_BITS-1:0] first_tri_c;
    logic [INDEX_BITS-1:0] second_tri_a;
    logic [INDEX_BITS-1:0] second_tri_b;
    logic [INDEX_BITS-1:0] second_tri_c;
    logic                  diagonal_sel;

    modport source (output valid, first_tri_a, first_tri_b, first_tri_c,
                    second_tri_a, second_tri_b, second_tri_c, diagonal_sel,
                    input ready);
    modport sink (input valid, first_tri_a, first_tri_b, first_tri_c,
                  second_tri_a, second_tri_b, second_tri_c, diagonal_sel,
                  output ready);
endinterface

@@ sv/qdt_mul.sv @@
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Unsigned OP_BITS x OP_BITS multiply, one 8-bit digit of the second operand
// per cycle, most significant digit first.
// ----------------------------------------------------------------------------
`include "quad_diagonal_triangulator_top_assert.svh"

module qdt_mul #(
    parameter int OP_BITS = 136
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [OP_BITS-1:0]     i_a,
    input  logic [OP_BITS-1:0]     i_b,
    output logic                   o_done,
    output logic [2*OP_BITS-1:0]   o_prod
);
    import qdt_pkg::*;

    localparam int PRD_BITS = 2 * OP_BITS;
    localparam int NDIG     = (OP_BITS + DIG_BITS - 1) / DIG_BITS;
    localparam int BPAD     = NDIG * DIG_BITS;
    localparam int CNT_BITS = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic [OP_BITS-1:0]          r_a;
    logic [BPAD-1:0]             r_b;
    logic [PRD_BITS-1:0]         r_acc;
    logic [PRD_BITS-1:0]         n_acc;
    logic [OP_BITS+DIG_BITS-1:0] pp;
    logic [CNT_BITS-1:0]         r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic                        last_dig;

    // Partial product of the top digit, then shift and accumulate
    assign pp       = r_a * r_b[BPAD-1 -: DIG_BITS];
    assign n_acc    = {r_acc[PRD_BITS-DIG_BITS-1:0], {DIG_BITS{1'b0}}} + PRD_BITS'(pp);
    assign last_dig = r_busy && (r_cnt == CNT_BITS'(NDIG - 1));

    // Sequence the digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= last_dig;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (last_dig) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Load operands, then advance one digit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= BPAD'(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b << DIG_BITS;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    `QDT_ASSERT(a_mul_start_idle, i_clk, i_rst_n, i_start |-> !r_busy)
    `QDT_ASSERT(a_mul_done_pulse, i_clk, i_rst_n, o_done |=> !o_done)
    `QDT_ASSERT_NR(a_mul_done_reset, i_clk, !i_rst_n |=> !o_done)

endmodule

@@ sv/qdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Triangulator controller
// Counts vertices of a quad and steps the datapath through its multiplies.
// ----------------------------------------------------------------------------
`include "quad_diagonal_triangulator_top_assert.svh"

module qdt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  qdt_pkg::t_stat i_stat,
    output qdt_pkg::t_cmd  o_cmd
);
    import qdt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [1:0] r_slot, n_slot;
    logic [2:0] r_kind, n_kind;
    logic       r_diag, n_diag;
    logic [1:0] r_comp, n_comp;
    logic       in_fire;

    // The first three vertices are stored at any time; the fourth waits for idle
    assign o_in_ready = (r_slot != SLOT_LAST) || (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        n_slot        = r_slot;
        n_kind        = r_kind;
        n_diag        = r_diag;
        n_comp        = r_comp;
        o_cmd         = '0;
        o_cmd.slot    = r_slot;
        o_cmd.kind    = r_kind;
        o_cmd.diag    = r_diag;
        o_cmd.comp    = r_comp;

        // Take a vertex request
        if (in_fire) begin
            if (r_slot != SLOT_LAST) begin
                o_cmd.hold_we = 1'b1;
                n_slot        = r_slot + 2'd1;
            end else begin
                o_cmd.load = 1'b1;
                n_slot     = '0;
                n_state    = ST_START;
                n_kind     = KIND_DOT;
                n_diag     = 1'b0;
                n_comp     = '0;
            end
        end

        case (r_state)
            ST_IDLE: begin
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                // Advance to the next multiply once the product is in
                if (i_stat.mul_done) begin
                    n_state = ST_START;
                    case (r_kind)
                        KIND_DOT: n_kind = KIND_SQA;
                        KIND_SQA: n_kind = KIND_SQB;
                        KIND_SQB: begin
                            if (r_comp == COMP_LAST) begin
                                n_kind = KIND_NORM;
                            end else begin
                                n_comp = r_comp + 2'd1;
                                n_kind = KIND_DOT;
                            end
                        end
                        KIND_NORM: begin
                            n_comp = '0;
                            if (!r_diag) begin
                                n_diag = 1'b1;
                                n_kind = KIND_DOT;
                            end else begin
                                n_diag = 1'b0;
                                n_kind = KIND_SQD;
                            end
                        end
                        KIND_SQD: begin
                            if (!r_diag) begin
                                n_diag = 1'b1;
                            end else begin
                                n_diag = 1'b0;
                                n_kind = KIND_LHS;
                            end
                        end
                        KIND_LHS: n_kind = KIND_RHS;
                        KIND_RHS: n_state = ST_EMIT;
                        default: n_kind = KIND_DOT;
                    endcase
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
            r_kind  <= KIND_DOT;
            r_diag  <= 1'b0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_kind  <= n_kind;
            r_diag  <= n_diag;
            r_comp  <= n_comp;
        end
    end

    `QDT_ASSERT(a_ctl_start_pulse, i_clk, i_rst_n, o_cmd.start |=> !o_cmd.start)
    `QDT_ASSERT(a_ctl_fourth_idle, i_clk, i_rst_n,
        o_in_ready && r_slot == SLOT_LAST |-> r_state == ST_IDLE)
    `QDT_ASSERT(a_ctl_done_waiting, i_clk, i_rst_n, i_stat.mul_done |-> r_state == ST_WAIT)

endmodule

@@ sv/qdt_dp.sv @@
// ----------------------------------------------------------------------------
// Triangulator datapath
// Vertex store, midpoint vectors, shared multiplier with its accumulators,
// cosine comparison and the output register.
// ----------------------------------------------------------------------------
module qdt_dp #(
    parameter int COORD_BITS = 32,
    parameter int INDEX_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  qdt_pkg::t_cmd                i_cmd,
    output qdt_pkg::t_stat               o_stat,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    input  logic [INDEX_BITS-1:0]        i_vertex_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [INDEX_BITS-1:0]        o_first_tri_a,
    output logic [INDEX_BITS-1:0]        o_first_tri_b,
    output logic [INDEX_BITS-1:0]        o_first_tri_c,
    output logic [INDEX_BITS-1:0]        o_second_tri_a,
    output logic [INDEX_BITS-1:0]        o_second_tri_b,
    output logic [INDEX_BITS-1:0]        o_second_tri_c,
    output logic                         o_diagonal_sel
);
    import qdt_pkg::*;

    // Doubled midpoint vectors, their squares and the final products
    localparam int VEC_BITS = COORD_BITS + 2;
    localparam int NRM_BITS = 2 * COORD_BITS + 4;
    localparam int DOT_BITS = NRM_BITS + 1;
    localparam int OP_BITS  = 2 * NRM_BITS;
    localparam int PRD_BITS = 2 * OP_BITS;

    // Cosine sign classes, ordered as negative < zero < positive
    localparam logic [1:0] SGN_NEG  = 2'd0;
    localparam logic [1:0] SGN_ZERO = 2'd1;
    localparam logic [1:0] SGN_POS  = 2'd2;

    logic signed [COORD_BITS-1:0] r_hc [3][3];
    logic [INDEX_BITS-1:0]        r_hi [3];
    logic signed [COORD_BITS-1:0] cur [3];
    logic signed [VEC_BITS-1:0]   ev [4][3];
    logic signed [VEC_BITS-1:0]   n_va [2][3];
    logic signed [VEC_BITS-1:0]   n_vb [2][3];
    logic signed [VEC_BITS-1:0]   r_va [2][3];
    logic signed [VEC_BITS-1:0]   r_vb [2][3];
    logic [INDEX_BITS-1:0]        r_ix [4];
    logic signed [DOT_BITS-1:0]   r_dot [2];
    logic [NRM_BITS-1:0]          r_na;
    logic [NRM_BITS-1:0]          r_nb;
    logic [OP_BITS-1:0]           r_p [2];
    logic [OP_BITS-1:0]           r_q [2];
    logic [PRD_BITS-1:0]          r_lhs;

    logic signed [VEC_BITS-1:0]   sel_a;
    logic signed [VEC_BITS-1:0]   sel_b;
    logic [VEC_BITS-1:0]          mag_a;
    logic [VEC_BITS-1:0]          mag_b;
    logic [DOT_BITS-1:0]          dot_abs [2];
    logic [NRM_BITS-1:0]          dmag [2];
    logic [OP_BITS-1:0]           op_a;
    logic [OP_BITS-1:0]           op_b;
    logic [PRD_BITS-1:0]          prod;
    logic signed [DOT_BITS-1:0]   prod_dot;
    logic                         mul_done;
    logic [1:0]                   s0;
    logic [1:0]                   s1;
    logic                         pick_first;
    logic                         r_out_valid;
    logic                         out_free;

    function automatic logic [1:0] sgn_code(input logic signed [DOT_BITS-1:0] dot,
                                            input logic [OP_BITS-1:0] nprod);
        logic [1:0] code;
        // A zero vector or a zero dot product counts as zero cosine
        if (nprod == '0 || dot == '0) begin
            code = SGN_ZERO;
        end else if (dot[DOT_BITS-1]) begin
            code = SGN_NEG;
        end else begin
            code = SGN_POS;
        end
        return code;
    endfunction

    assign cur[0] = i_coord_x;
    assign cur[1] = i_coord_y;
    assign cur[2] = i_coord_z;

    // Store the first three vertices
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_we) begin
            r_hc[i_cmd.slot][0] <= i_coord_x;
            r_hc[i_cmd.slot][1] <= i_coord_y;
            r_hc[i_cmd.slot][2] <= i_coord_z;
            r_hi[i_cmd.slot]    <= i_vertex_index;
        end
    end

    // Doubled vectors from each diagonal's midpoint to the two other vertices
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                ev[j][k] = VEC_BITS'(r_hc[j][k]);
            end
            ev[3][k]   = VEC_BITS'(cur[k]);
            n_va[0][k] = (ev[1][k] <<< 1) - ev[0][k] - ev[2][k];
            n_vb[0][k] = (ev[3][k] <<< 1) - ev[0][k] - ev[2][k];
            n_va[1][k] = (ev[2][k] <<< 1) - ev[1][k] - ev[3][k];
            n_vb[1][k] = (ev[0][k] <<< 1) - ev[1][k] - ev[3][k];
        end
    end

    // Operand selection for the shared multiplier
    assign sel_a = r_va[i_cmd.diag][i_cmd.comp];
    assign sel_b = r_vb[i_cmd.diag][i_cmd.comp];
    assign mag_a = sel_a[VEC_BITS-1] ? unsigned'(-sel_a) : unsigned'(sel_a);
    assign mag_b = sel_b[VEC_BITS-1] ? unsigned'(-sel_b) : unsigned'(sel_b);

    always_comb begin
        for (int d = 0; d < 2; d++) begin
            dot_abs[d] = r_dot[d][DOT_BITS-1] ? unsigned'(-r_dot[d]) : unsigned'(r_dot[d]);
            dmag[d]    = dot_abs[d][NRM_BITS-1:0];
        end
    end

    always_comb begin
        case (i_cmd.kind)
            KIND_DOT: begin
                op_a = OP_BITS'(mag_a);
                op_b = OP_BITS'(mag_b);
            end
            KIND_SQA: begin
                op_a = OP_BITS'(mag_a);
                op_b = OP_BITS'(mag_a);
            end
            KIND_SQB: begin
                op_a = OP_BITS'(mag_b);
                op_b = OP_BITS'(mag_b);
            end
            KIND_NORM: begin
                op_a = OP_BITS'(r_na);
                op_b = OP_BITS'(r_nb);
            end
            KIND_SQD: begin
                op_a = OP_BITS'(dmag[i_cmd.diag]);
                op_b = OP_BITS'(dmag[i_cmd.diag]);
            end
            KIND_LHS: begin
                op_a = r_q[0];
                op_b = r_p[1];
            end
            KIND_RHS: begin
                op_a = r_q[1];
                op_b = r_p[0];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    qdt_mul #(
        .OP_BITS (OP_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    assign prod_dot = signed'(prod[DOT_BITS-1:0]);

    // Capture vectors on the fourth vertex, then accumulate the products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_va     <= n_va;
            r_vb     <= n_vb;
            r_ix[0]  <= r_hi[0];
            r_ix[1]  <= r_hi[1];
            r_ix[2]  <= r_hi[2];
            r_ix[3]  <= i_vertex_index;
            r_dot[0] <= '0;
            r_dot[1] <= '0;
            r_na     <= '0;
            r_nb     <= '0;
        end else if (mul_done) begin
            case (i_cmd.kind)
                KIND_DOT: begin
                    if (sel_a[VEC_BITS-1] ^ sel_b[VEC_BITS-1]) begin
                        r_dot[i_cmd.diag] <= r_dot[i_cmd.diag] - prod_dot;
                    end else begin
                        r_dot[i_cmd.diag] <= r_dot[i_cmd.diag] + prod_dot;
                    end
                end
                KIND_SQA: r_na <= r_na + prod[NRM_BITS-1:0];
                KIND_SQB: r_nb <= r_nb + prod[NRM_BITS-1:0];
                KIND_NORM: begin
                    r_p[i_cmd.diag] <= prod[OP_BITS-1:0];
                    r_na            <= '0;
                    r_nb            <= '0;
                end
                KIND_SQD: r_q[i_cmd.diag] <= prod[OP_BITS-1:0];
                KIND_LHS: r_lhs <= prod;
                default: begin
                end
            endcase
        end
    end

    // Pick the diagonal: the right-hand product is still held in the multiplier
    always_comb begin
        s0 = sgn_code(r_dot[0], r_p[0]);
        s1 = sgn_code(r_dot[1], r_p[1]);
        if (s0 != s1) begin
            pick_first = (s0 < s1);
        end else if (s0 == SGN_ZERO) begin
            pick_first = 1'b1;
        end else if (s0 == SGN_POS) begin
            pick_first = (r_lhs <= prod);
        end else begin
            pick_first = (r_lhs >= prod);
        end
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (pick_first) begin
                o_first_tri_a  <= r_ix[0];
                o_first_tri_b  <= r_ix[1];
                o_first_tri_c  <= r_ix[2];
                o_second_tri_a <= r_ix[0];
                o_second_tri_b <= r_ix[2];
                o_second_tri_c <= r_ix[3];
                o_diagonal_sel <= 1'b0;
            end else begin
                o_first_tri_a  <= r_ix[1];
                o_first_tri_b  <= r_ix[2];
                o_first_tri_c  <= r_ix[3];
                o_second_tri_a <= r_ix[1];
                o_second_tri_b <= r_ix[3];
                o_second_tri_c <= r_ix[0];
                o_diagonal_sel <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.mul_done = mul_done;
    assign o_stat.out_free = out_free;

endmodule

@@ sv/quad_diagonal_triangulator_top.sv @@
// The first three vertices of a quad are taken one a cycle; the fourth starts 24 multiplies
// on the shared 8-bit-digit multiplier, each over NDIG = ceil((4*COORD_BITS+8)/8) digits (17 by
// default), and the triangles are emitted after the last. A new quad's first three vertices
// are stored meanwhile; its fourth waits until the current triangles enter the output register.
// Reset (synchronous, active low) clears the vertex count, the controller and the
// output valid; stored vertices and arithmetic registers keep their contents.
// ----------------------------------------------------------------------------
// Quad diagonal triangulator
// Splits a quad into two triangles along the diagonal with the smaller
// midpoint cosine, compared exactly in integer arithmetic.
// ----------------------------------------------------------------------------
module quad_diagonal_triangulator_top #(
    parameter int COORD_BITS = 32,
    parameter int INDEX_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qdt_vertex_if.sink    i_vtx,
    qdt_tri_if.source     o_tri
);
    import qdt_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    qdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vtx.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_vtx.ready = in_ready;

    qdt_dp #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_coord_x      (i_vtx.coord_x),
        .i_coord_y      (i_vtx.coord_y),
        .i_coord_z      (i_vtx.coord_z),
        .i_vertex_index (i_vtx.vertex_index),
        .o_out_valid    (o_tri.valid),
        .i_out_ready    (o_tri.ready),
        .o_first_tri_a  (o_tri.first_tri_a),
        .o_first_tri_b  (o_tri.first_tri_b),
        .o_first_tri_c  (o_tri.first_tri_c),
        .o_second_tri_a (o_tri.second_tri_a),
        .o_second_tri_b (o_tri.second_tri_b),
        .o_second_tri_c (o_tri.second_tri_c),
        .o_diagonal_sel (o_tri.diagonal_sel)
    );

endmodule

@@ sim/tb_quad_diagonal_triangulator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad diagonal triangulator testbench
// Streams quads of vertices into the triangulator, predicts the chosen split
// with exact wide-integer cosine comparison and checks every triangle pair.
// ----------------------------------------------------------------------------
module tb_quad_diagonal_triangulator_top;

    localparam int COORD_BITS   = 32;
    localparam int INDEX_BITS   = 24;
    localparam int RANDOM_QUADS = 200;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 600;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [INDEX_BITS-1:0]        t_index;
    // Midpoint vectors and dot products, wide enough for exact sums
    typedef logic signed [95:0]           t_wide;
    // Products of squared norms and squared dots
    typedef logic [319:0]                 t_big;

    typedef struct packed {
        t_index first_a;
        t_index first_b;
        t_index first_c;
        t_index second_a;
        t_index second_b;
        t_index second_c;
        logic   diag;
    } t_tri_pair;

    localparam t_coord MAX_C = 32'sh7FFF_FFFF;
    localparam t_coord MIN_C = 32'sh8000_0000;
    localparam t_coord ONE   = 32'sh0001_0000;
    localparam t_index MAX_I = {INDEX_BITS{1'b1}};

    // ------------------------------------------------------------------------
    // Split predictor and store of expected triangle pairs
    // ------------------------------------------------------------------------
    class quad_scoreboard;
        t_coord     held_x[3];
        t_coord     held_y[3];
        t_coord     held_z[3];
        t_index     held_idx[3];
        logic [1:0] slot;
        t_tri_pair  tri_q[$];
        int         errors;

        function new();
            slot   = '0;
            errors = 0;
        endfunction

        function int pending();
            return tri_q.size();
        endfunction

        // Sign and magnitude of the dot product, with |a|^2*|b|^2
        function void midpoint_cosine(input t_wide ax, input t_wide ay, input t_wide az,
                                      input t_wide bx, input t_wide by, input t_wide bz,
                                      output int sgn, output t_big dmag,
                                      output t_big norms);
            t_wide dot;
            t_big  na;
            t_big  nb;
            dot   = ax * bx + ay * by + az * bz;
            na    = t_big'(ax * ax + ay * ay + az * az);
            nb    = t_big'(bx * bx + by * by + bz * bz);
            norms = na * nb;
            if (norms == '0 || dot == '0) begin
                sgn  = 0;
                dmag = '0;
            end else if (dot < 0) begin
                sgn  = -1;
                dmag = t_big'(-dot);
            end else begin
                sgn  = 1;
                dmag = t_big'(dot);
            end
        endfunction

        // Hold the first three vertices; the fourth closes the quad
        function void note_vertex(t_coord x, t_coord y, t_coord z, t_index idx);
            t_wide     vx[4];
            t_wide     vy[4];
            t_wide     vz[4];
            t_index    vi[4];
            int        s0;
            int        s1;
            t_big      d0;
            t_big      d1;
            t_big      n0;
            t_big      n1;
            t_big      lhs;
            t_big      rhs;
            logic      take_first;
            t_tri_pair t;
            if (slot != qdt_pkg::SLOT_LAST) begin
                held_x[slot]   = x;
                held_y[slot]   = y;
                held_z[slot]   = z;
                held_idx[slot] = idx;
                slot = slot + 2'd1;
                return;
            end
            slot = '0;
            for (int k = 0; k < 3; k++) begin
                vx[k] = t_wide'(held_x[k]);
                vy[k] = t_wide'(held_y[k]);
                vz[k] = t_wide'(held_z[k]);
                vi[k] = held_idx[k];
            end
            vx[3] = t_wide'(x);
            vy[3] = t_wide'(y);
            vz[3] = t_wide'(z);
            vi[3] = idx;

            // Vectors scaled by two, from each diagonal's midpoint
            midpoint_cosine(2 * vx[1] - (vx[0] + vx[2]), 2 * vy[1] - (vy[0] + vy[2]),
                            2 * vz[1] - (vz[0] + vz[2]), 2 * vx[3] - (vx[0] + vx[2]),
                            2 * vy[3] - (vy[0] + vy[2]), 2 * vz[3] - (vz[0] + vz[2]),
                            s0, d0, n0);
            midpoint_cosine(2 * vx[2] - (vx[1] + vx[3]), 2 * vy[2] - (vy[1] + vy[3]),
                            2 * vz[2] - (vz[1] + vz[3]), 2 * vx[0] - (vx[1] + vx[3]),
                            2 * vy[0] - (vy[1] + vy[3]), 2 * vz[0] - (vz[1] + vz[3]),
                            s1, d1, n1);

            // Lower or equal cosine wins, ties to v0-v2
            if (s0 != s1) begin
                take_first = (s0 < s1);
            end else if (s0 == 0) begin
                take_first = 1'b1;
            end else begin
                lhs = d0 * d0 * n1;
                rhs = d1 * d1 * n0;
                take_first = (s0 > 0) ? (lhs <= rhs) : (lhs >= rhs);
            end

            if (take_first) begin
                t = '{first_a: vi[0], first_b: vi[1], first_c: vi[2],
                      second_a: vi[0], second_b: vi[2], second_c: vi[3], diag: 1'b0};
            end else begin
                t = '{first_a: vi[1], first_b: vi[2], first_c: vi[3],
                      second_a: vi[1], second_b: vi[3], second_c: vi[0], diag: 1'b1};
            end
            tri_q.push_back(t);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one triangle pair with the oldest expectation
        function void check_tri(t_tri_pair got);
            t_tri_pair want;
            if (tri_q.size() == 0) begin
                $display("%0t: unexpected triangle pair, expected none, got %0h",
                         $time, got);
                errors++;
                return;
            end
            want = tri_q.pop_front();
            check_field("first_tri_a", want.first_a, got.first_a);
            check_field("first_tri_b", want.first_b, got.first_b);
            check_field("first_tri_c", want.first_c, got.first_c);
            check_field("second_tri_a", want.second_a, got.second_a);
            check_field("second_tri_b", want.second_b, got.second_b);
            check_field("second_tri_c", want.second_c, got.second_c);
            check_field("diagonal_sel", want.diag, got.diag);
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    quad_scoreboard sb;
    int             phase;
    int             tx_idle_pct;
    int             rx_idle_pct;
    logic           hold_done;
    t_coord         qx[4];
    t_coord         qy[4];
    t_coord         qz[4];
    t_index         qi[4];

    qdt_vertex_if #(.COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS)) vtx_bus ();
    qdt_tri_if #(.INDEX_BITS(INDEX_BITS)) tri_bus ();

    quad_diagonal_triangulator_top #(
        .COORD_BITS(COORD_BITS),
        .INDEX_BITS(INDEX_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (vtx_bus),
        .o_tri  (tri_bus)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offset of random scale around a base point
    function automatic t_coord jitter(t_coord base);
        jitter = base + (t_coord'($signed($urandom)) >>> $urandom_range(1, 31));
    endfunction

    task automatic load_vertex(int n, t_coord x, t_coord y, t_coord z, t_index idx);
        qx[n] = x;
        qy[n] = y;
        qz[n] = z;
        qi[n] = idx;
    endtask

    // Offer one vertex request and hold it until taken
    task automatic send_vertex(t_coord x, t_coord y, t_coord z, t_index idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            vtx_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        vtx_bus.valid        <= 1'b1;
        vtx_bus.coord_x      <= x;
        vtx_bus.coord_y      <= y;
        vtx_bus.coord_z      <= z;
        vtx_bus.vertex_index <= idx;
        do @(posedge i_clk); while (!vtx_bus.ready);
        sb.note_vertex(x, y, z, idx);
        @(negedge i_clk);
    endtask

    task automatic send_quad();
        for (int n = 0; n < 4; n++)
            send_vertex(qx[n], qy[n], qz[n], qi[n]);
    endtask

    // Random quad of one of several shapes
    task automatic send_random_quad();
        t_coord bx;
        t_coord by;
        t_coord bz;
        t_coord dx;
        t_coord dy;
        t_coord dz;
        int     style;
        style = $urandom_range(9);
        bx = $urandom;
        by = $urandom;
        bz = $urandom;
        for (int n = 0; n < 4; n++) begin
            case (style)
                0, 1, 2: begin
                    qx[n] = $urandom;
                    qy[n] = $urandom;
                    qz[n] = $urandom;
                end
                9: begin
                    qx[n] = t_coord'($urandom_range(7) << 16);
                    qy[n] = t_coord'($urandom_range(7) << 16);
                    qz[n] = $urandom_range(1) ? '0 : t_coord'($urandom_range(3) << 16);
                end
                default: begin
                    qx[n] = jitter(bx);
                    qy[n] = jitter(by);
                    qz[n] = jitter(bz);
                end
            endcase
            case ($urandom_range(7))
                0:       qi[n] = '0;
                1:       qi[n] = MAX_I;
                default: qi[n] = t_index'($urandom);
            endcase
        end
        if (style == 7) begin
            // Parallelogram: both cosines are minus one
            qx[3] = qx[0] + qx[2] - qx[1];
            qy[3] = qy[0] + qy[2] - qy[1];
            qz[3] = qz[0] + qz[2] - qz[1];
        end else if (style == 8) begin
            // One vertex on a diagonal's midpoint: zero vector
            dx = jitter('0);
            dy = jitter('0);
            dz = jitter('0);
            if ($urandom_range(1)) begin
                qx[2] = qx[1] + dx;
                qy[2] = qy[1] + dy;
                qz[2] = qz[1] + dz;
                qx[3] = qx[1] + 2 * dx;
                qy[3] = qy[1] + 2 * dy;
                qz[3] = qz[1] + 2 * dz;
            end else begin
                qx[1] = qx[0] + dx;
                qy[1] = qy[0] + dy;
                qz[1] = qz[0] + dz;
                qx[2] = qx[0] + 2 * dx;
                qy[2] = qy[0] + 2 * dy;
                qz[2] = qz[0] + 2 * dz;
            end
        end
        send_quad();
    endtask

    // Take triangle pairs; one long hold-off on entering the last phase
    initial begin
        tri_bus.ready = 1'b0;
        hold_done     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && phase == 2 && !hold_done) begin
                hold_done = 1'b1;
                tri_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                tri_bus.ready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Check every accepted triangle pair
    always @(posedge i_clk) begin
        if (i_rst_n && tri_bus.valid && tri_bus.ready)
            sb.check_tri(t_tri_pair'{tri_bus.first_tri_a, tri_bus.first_tri_b,
                                     tri_bus.first_tri_c, tri_bus.second_tri_a,
                                     tri_bus.second_tri_b, tri_bus.second_tri_c,
                                     tri_bus.diagonal_sel});
    end

    // Stimulus
    initial begin
        sb                   = new();
        phase                = 0;
        tx_idle_pct          = 10;
        rx_idle_pct          = 46;
        i_rst_n              = 1'b0;
        vtx_bus.valid        = 1'b0;
        vtx_bus.coord_x      = '0;
        vtx_bus.coord_y      = '0;
        vtx_bus.coord_z      = '0;
        vtx_bus.vertex_index = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Degenerate quad at the origin, extreme indices
        load_vertex(0, '0, '0, '0, '0);
        load_vertex(1, '0, '0, '0, MAX_I);
        load_vertex(2, '0, '0, '0, '0);
        load_vertex(3, '0, '0, '0, MAX_I);
        send_quad();
        // Degenerate quad at the largest coordinate
        load_vertex(0, MAX_C, MAX_C, MAX_C, 24'h123456);
        load_vertex(1, MAX_C, MAX_C, MAX_C, 24'hABCDEF);
        load_vertex(2, MAX_C, MAX_C, MAX_C, 24'h555555);
        load_vertex(3, MAX_C, MAX_C, MAX_C, 24'hAAAAAA);
        send_quad();
        // Alternating coordinate extremes
        load_vertex(0, MAX_C, MIN_C, MAX_C, MAX_I);
        load_vertex(1, MIN_C, MAX_C, MIN_C, '0);
        load_vertex(2, MAX_C, MAX_C, MIN_C, 24'h0F0F0F);
        load_vertex(3, MIN_C, MIN_C, MAX_C, 24'hF0F0F0);
        send_quad();
        // v1 on the midpoint of v0-v2: zero vector
        load_vertex(0, '0, '0, '0, 24'd10);
        load_vertex(1, ONE, ONE, ONE, 24'd11);
        load_vertex(2, 2 * ONE, 2 * ONE, 2 * ONE, 24'd12);
        load_vertex(3, '0, 5 * ONE, '0, 24'd13);
        send_quad();
        // Unit square: equal cosines
        load_vertex(0, '0, '0, '0, 24'd20);
        load_vertex(1, ONE, '0, '0, 24'd21);
        load_vertex(2, ONE, ONE, '0, 24'd22);
        load_vertex(3, '0, ONE, '0, 24'd23);
        send_quad();
        // Skewed quad that favours the v1-v3 diagonal
        load_vertex(0, 10 * ONE, '0, '0, 24'd30);
        load_vertex(1, 11 * ONE, ONE, '0, 24'd31);
        load_vertex(2, '0, 10 * ONE, '0, 24'd32);
        load_vertex(3, '0, '0, '0, 24'd33);
        send_quad();

        // Random quads across the three idling phases
        for (int q = 0; q < RANDOM_QUADS; q++) begin
            if (q == RANDOM_QUADS / 3) begin
                phase       = 1;
                tx_idle_pct = 46;
                rx_idle_pct = 10;
            end else if (q == 2 * RANDOM_QUADS / 3) begin
                phase       = 2;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_random_quad();
        end
        vtx_bus.valid <= 1'b0;

        // Drain outstanding triangle pairs
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
